/* design/nhr_pkg.sv */
// Shared types, codes and checksum helpers for the NAT header rewrite block.
`default_nettype none
package nhr_pkg;

  localparam int FLOW_ENTRIES_DEF = 1024;
  localparam int IDX_W = 10;

  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  localparam logic [1:0] WORD_ADDRS   = 2'd0;
  localparam logic [1:0] WORD_PORTS   = 2'd1;
  localparam logic [1:0] WORD_DELTAS  = 2'd2;
  localparam logic [1:0] WORD_VERSION = 2'd3;

  localparam logic [1:0] DISP_NEXT   = 2'd0;
  localparam logic [1:0] DISP_DROP   = 2'd1;
  localparam logic [1:0] DISP_LOOKUP = 2'd2;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Bit positions within the six op bits of entry word 1.
  localparam int OP_SADDR  = 0;
  localparam int OP_DADDR  = 1;
  localparam int OP_SPORT  = 2;
  localparam int OP_DPORT  = 3;
  localparam int OP_ICMPID = 4;
  localparam int OP_TXFIB  = 5;

  typedef struct packed {
    logic             command;
    logic [IDX_W-1:0] flow_index;
    logic [31:0]      sess_ver;
    logic [15:0]      ip_checksum;
    logic [31:0]      src_addr;
    logic [31:0]      dst_addr;
    logic [15:0]      l4_checksum;
    logic [15:0]      sport;
    logic [15:0]      dport;
    logic [15:0]      icmp_ident;
    logic [1:0]       entry_word;
    logic [63:0]      entry_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  disposition;
    logic [15:0] new_ip_checksum;
    logic [31:0] new_src_addr;
    logic [31:0] new_dst_addr;
    logic [15:0] new_l4_checksum;
    logic [15:0] new_sport;
    logic [15:0] new_dport;
    logic [15:0] new_icmp_ident;
    logic        tx_fib_set;
    logic [31:0] tx_fib_index;
  } out_item_t;

  // Subtract with end-around borrow in 64 bits.
  function automatic logic [63:0] csum_sub(input logic [63:0] c, input logic [63:0] x);
    logic [63:0] d;
    d = c - x;
    if (x > c) begin
      d = d - 64'd1;
    end
    return d;
  endfunction

  // Fold a 64-bit sum down to 16 bits.
  function automatic logic [15:0] csum_fold(input logic [63:0] c);
    logic [63:0] s;
    s = {32'd0, c[31:0]} + {32'd0, c[63:32]};
    s = {32'd0, s[31:0]} + {32'd0, s[63:32]};
    s = {48'd0, s[15:0]} + {16'd0, s[63:16]};
    s = {48'd0, s[15:0]} + {16'd0, s[63:16]};
    return s[15:0];
  endfunction

endpackage
`default_nettype wire

/* design/nhr_in_if.sv */
// Handshake channel that carries request items into the block.
`default_nettype none
interface nhr_in_if;
  import nhr_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/nhr_out_if.sv */
// Handshake channel that carries result items out of the block.
`default_nettype none
interface nhr_out_if;
  import nhr_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* design/nat_header_rewrite.sv */
// Top level of the NAT header rewrite block: flow table, lookup and header edit.
`default_nettype none
// The block takes one item per clock cycle while results are taken. A write item
// stores one word of a flow entry and gives no result; a packet item gives exactly
// one result item. The four entry words are read into a register at the edge that
// accepts the packet, and the rewrite and checksum logic then works from that
// register into the output register. Because the table is read at acceptance, a
// write is seen by every packet accepted after it and by none accepted before it.
// The flow table needs no clearing after reset; a packet that looks up an entry
// never written gets an unspecified result. When the result side stalls, the
// compute stage holds and the request side stops taking items once both stages
// are full.
module nat_header_rewrite #(
  parameter int FLOW_ENTRIES = nhr_pkg::FLOW_ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_wr_en,
  input  wire logic cfg_wr_data,
  nhr_in_if.sink    request,
  nhr_out_if.source result
);
  import nhr_pkg::*;

  localparam int AW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

  // Terminal mode chooses between ip4 lookup and the next service.
  logic terminal_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      terminal_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      terminal_mode <= cfg_wr_data;
    end
  end

  // Flow table address, widened or narrowed to the table depth.
  logic [AW+IDX_W-1:0] idx_ext;
  logic [AW-1:0]       addr;
  logic                in_range;
  logic                accept;

  assign idx_ext  = (AW + IDX_W)'(request.data.flow_index);
  assign addr     = idx_ext[AW-1:0];
  assign in_range = 32'(request.data.flow_index) < 32'(FLOW_ENTRIES);
  assign accept   = request.valid && request.ready;

  logic [63:0] mem_addrs   [FLOW_ENTRIES];
  logic [61:0] mem_ports   [FLOW_ENTRIES];
  logic [63:0] mem_deltas  [FLOW_ENTRIES];
  logic [63:0] mem_version [FLOW_ENTRIES];

  logic [63:0] rd_addrs;
  logic [61:0] rd_ports;
  logic [63:0] rd_deltas;
  logic [63:0] rd_version;

  // Writes go to the word chosen by the item; indices past the table are ignored.
  always_ff @(posedge clk) begin
    if (accept && request.data.command == CMD_WRITE && in_range) begin
      case (request.data.entry_word)
        WORD_ADDRS:   mem_addrs[addr]   <= request.data.entry_data;
        WORD_PORTS:   mem_ports[addr]   <= request.data.entry_data[61:0];
        WORD_DELTAS:  mem_deltas[addr]  <= request.data.entry_data;
        WORD_VERSION: mem_version[addr] <= request.data.entry_data;
        default:      mem_version[addr] <= request.data.entry_data;
      endcase
    end
  end

  // All four words are read together; the read register holds while stalled.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_addrs   <= mem_addrs[addr];
      rd_ports   <= mem_ports[addr];
      rd_deltas  <= mem_deltas[addr];
      rd_version <= mem_version[addr];
    end
  end

  // Compute stage: the packet header and its range flag sit beside the read data.
  logic     s1_valid;
  logic     s1_in_range;
  in_item_t s1;
  logic     s1_adv;

  assign s1_adv        = s1_valid && (!result.valid || result.ready);
  assign request.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= (request.data.command == CMD_PACKET);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1          <= request.data;
      s1_in_range <= in_range;
    end
  end

  // Rewrite logic. A missing or stale entry drops the packet untouched; an
  // unknown protocol keeps the IP edits but still drops it.
  logic        hit;
  logic [5:0]  ops;
  logic [7:0]  proto;
  logic [63:0] l3d;
  logic [63:0] l4d;
  out_item_t   res_next;

  assign hit   = s1_in_range && (rd_version[31:0] == s1.sess_ver);
  assign ops   = rd_ports[61:56];
  assign proto = rd_ports[55:48];
  assign l3d   = {32'd0, rd_deltas[31:0]};
  assign l4d   = {32'd0, rd_deltas[63:32]};

  always_comb begin
    res_next.disposition     = DISP_DROP;
    res_next.new_ip_checksum = s1.ip_checksum;
    res_next.new_src_addr    = s1.src_addr;
    res_next.new_dst_addr    = s1.dst_addr;
    res_next.new_l4_checksum = s1.l4_checksum;
    res_next.new_sport       = s1.sport;
    res_next.new_dport       = s1.dport;
    res_next.new_icmp_ident  = s1.icmp_ident;
    res_next.tx_fib_set      = 1'b0;
    res_next.tx_fib_index    = 32'd0;
    if (hit) begin
      res_next.new_ip_checksum = csum_fold(csum_sub({48'd0, s1.ip_checksum}, l3d));
      if (ops[OP_SADDR]) begin
        res_next.new_src_addr = rd_addrs[31:0];
      end
      if (ops[OP_DADDR]) begin
        res_next.new_dst_addr = rd_addrs[63:32];
      end
      if (proto == PROTO_ICMP) begin
        res_next.new_l4_checksum = csum_fold(csum_sub({48'd0, s1.l4_checksum}, l4d));
        if (ops[OP_ICMPID]) begin
          res_next.new_icmp_ident = rd_ports[47:32];
        end
      end else if (proto == PROTO_TCP || proto == PROTO_UDP) begin
        // Transport checksums cover the pseudo-header, so both deltas apply.
        res_next.new_l4_checksum =
          csum_fold(csum_sub(csum_sub({48'd0, s1.l4_checksum}, l3d), l4d));
        if (ops[OP_SPORT]) begin
          res_next.new_sport = rd_ports[15:0];
        end
        if (ops[OP_DPORT]) begin
          res_next.new_dport = rd_ports[31:16];
        end
      end
      if (proto == PROTO_ICMP || proto == PROTO_TCP || proto == PROTO_UDP) begin
        if (ops[OP_TXFIB]) begin
          res_next.tx_fib_set   = 1'b1;
          res_next.tx_fib_index = rd_version[63:32];
        end
        res_next.disposition = terminal_mode ? DISP_LOOKUP : DISP_NEXT;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.data <= res_next;
    end
  end

endmodule
`default_nettype wire
